// ===== rtl/eidsig_pkg.sv =====
// Shared codes, defaults and control structs of the entity id allocator.
`timescale 1ns / 1ps
`default_nettype none
package eidsig_pkg;

  localparam int ENTITIES_DEF   = 1024;
  localparam int COMPONENTS_DEF = 32;

  // Fixed port widths
  localparam int OP_W     = 2;
  localparam int ID_PORT_W = 10;
  localparam int SIG_PORT_W = 32;
  localparam int STAT_W   = 2;

  // Opcodes
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_SET_SIG = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_FREE   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_ALIVE = 2'd2;

  // Free queue control and status
  typedef struct packed {
    logic pop;
    logic push;
  } qctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  // Entity store write enables
  typedef struct packed {
    logic alive_we;
    logic alive_val;
    logic sig_we;
  } estore_wr_t;

endpackage
`default_nettype wire

// ===== rtl/entity_id_allocator_signature_table_top.sv =====
// Top level of the entity id allocator with per-id component signature table.
// Sequencing: a command taken at a start edge executes in the next cycle; its result is then
//   registered onto the out_ ports with out_valid high for one cycle.
// Commands: a new command is not taken until the last one has executed (synchronous read of
//   the id memories, then compute and write back); busy is high during the execute cycle.
// Reset: synchronous, rst_n low; afterwards busy stays high while every alive bit and
//   signature is swept to zero. Results cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module entity_id_allocator_signature_table_top #(
  parameter int ENTITIES   = eidsig_pkg::ENTITIES_DEF,
  parameter int COMPONENTS = eidsig_pkg::COMPONENTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // command side
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [eidsig_pkg::OP_W-1:0]         in_opcode,
  input  wire logic [eidsig_pkg::ID_PORT_W-1:0]    in_entity_id,
  input  wire logic [eidsig_pkg::SIG_PORT_W-1:0]   in_new_signature,
  input  wire logic [eidsig_pkg::SIG_PORT_W-1:0]   in_component_mask,
  // result side
  output logic                                     out_valid,
  output logic [eidsig_pkg::STAT_W-1:0]            out_status,
  output logic [eidsig_pkg::ID_PORT_W-1:0]         out_granted_id,
  output logic                                     out_is_alive,
  output logic [eidsig_pkg::SIG_PORT_W-1:0]        out_current_signature,
  output logic                                     out_has_all,
  output logic                                     out_has_any
);

  localparam int ID_W  = $clog2(ENTITIES);
  localparam int CNT_W = $clog2(ENTITIES+1);
  localparam int SIG_W = (COMPONENTS < eidsig_pkg::SIG_PORT_W) ? COMPONENTS :
                         eidsig_pkg::SIG_PORT_W;
  // ids are compared on 17 bits so the bound fits for the largest pool
  localparam int CMP_W = 17;
  localparam logic [CMP_W-1:0] ENT_BOUND = CMP_W'(ENTITIES);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(ENTITIES);

  // Sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic accept, exec;

  // Command captured at the start transfer
  logic [eidsig_pkg::OP_W-1:0] op_r;
  logic [ID_W-1:0]             id_r;
  logic                        id_ok_r;
  logic [SIG_W-1:0]            nsig_r;
  logic [SIG_W-1:0]            mask_r;

  // Submodule wiring
  eidsig_pkg::qctl_t      qctl;
  eidsig_pkg::qstat_t     qstat;
  eidsig_pkg::estore_wr_t ewr;
  logic [ID_W-1:0]        q_head_id;
  logic [CNT_W-1:0]       q_count;
  logic [ID_W-1:0]        alive_addr;
  logic                   rd_alive;
  logic [SIG_W-1:0]       rd_sig;
  logic                   clearing;

  // Result staging
  logic                                  out_valid_r;
  logic [eidsig_pkg::STAT_W-1:0]         status_nxt, status_r;
  logic [eidsig_pkg::ID_PORT_W-1:0]      granted_nxt, granted_r;
  logic                                  alive_nxt, alive_r;
  logic [SIG_W-1:0]                      sig_nxt;
  logic [eidsig_pkg::SIG_PORT_W-1:0]     sig_r;
  logic                                  all_nxt, all_r;
  logic                                  any_nxt, any_r;

  assign busy   = clearing || (state_r == ST_EXEC);
  assign accept = start && !busy;
  assign exec   = (state_r == ST_EXEC);

  always_comb begin
    case (state_r)
      ST_IDLE: state_nxt = accept ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= exec;
    end
  end

  // Signature and mask bits above the component count are dropped here
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_opcode;
      id_r    <= ID_W'(in_entity_id);
      id_ok_r <= (CMP_W'(in_entity_id) < ENT_BOUND);
      nsig_r  <= SIG_W'(in_new_signature);
      mask_r  <= SIG_W'(in_component_mask);
    end
  end

  // Execute: memory read data is valid, decide writes and the result
  always_comb begin
    qctl        = '0;
    ewr         = '0;
    alive_addr  = id_r;
    status_nxt  = eidsig_pkg::STAT_OK;
    granted_nxt = '0;
    alive_nxt   = 1'b0;
    sig_nxt     = '0;
    all_nxt     = 1'b0;
    any_nxt     = 1'b0;
    if (exec) begin
      case (op_r)
        eidsig_pkg::OP_ALLOC: begin
          if (qstat.empty) begin
            status_nxt = eidsig_pkg::STAT_NO_FREE;
          end else begin
            qctl.pop      = 1'b1;
            ewr.alive_we  = 1'b1;
            ewr.alive_val = 1'b1;
            alive_addr    = q_head_id;
            granted_nxt   = eidsig_pkg::ID_PORT_W'(q_head_id);
          end
        end
        eidsig_pkg::OP_RELEASE: begin
          if (!id_ok_r || !rd_alive || qstat.full) begin
            status_nxt = eidsig_pkg::STAT_NOT_ALIVE;
          end else begin
            qctl.push     = 1'b1;
            ewr.alive_we  = 1'b1;
            ewr.alive_val = 1'b0;
          end
        end
        eidsig_pkg::OP_SET_SIG: begin
          ewr.sig_we = id_ok_r;
        end
        eidsig_pkg::OP_QUERY: begin
          alive_nxt = id_ok_r && rd_alive;
          sig_nxt   = id_ok_r ? rd_sig : '0;
          all_nxt   = ((mask_r & sig_nxt) == mask_r);
          any_nxt   = ((mask_r & sig_nxt) != '0);
        end
        default: begin
          status_nxt = eidsig_pkg::STAT_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      status_r  <= status_nxt;
      granted_r <= granted_nxt;
      alive_r   <= alive_nxt;
      sig_r     <= eidsig_pkg::SIG_PORT_W'(sig_nxt);
      all_r     <= all_nxt;
      any_r     <= any_nxt;
    end
  end

  eidsig_free_queue #(
    .ENTITIES (ENTITIES)
  ) u_free_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (qctl),
    .push_id (id_r),
    .head_id (q_head_id),
    .count   (q_count),
    .stat    (qstat)
  );

  eidsig_entity_store #(
    .ENTITIES   (ENTITIES),
    .COMPONENTS (COMPONENTS)
  ) u_entity_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (accept),
    .rd_addr    (ID_W'(in_entity_id)),
    .wr         (ewr),
    .alive_addr (alive_addr),
    .sig_addr   (id_r),
    .sig_data   (nsig_r),
    .rd_alive   (rd_alive),
    .rd_sig     (rd_sig),
    .clearing   (clearing)
  );

  assign out_valid             = out_valid_r;
  assign out_status            = status_r;
  assign out_granted_id        = granted_r;
  assign out_is_alive          = alive_r;
  assign out_current_signature = sig_r;
  assign out_has_all           = all_r;
  assign out_has_any           = any_r;

  // Checks
  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_EXEC))
    else $error("result strobe without an execute cycle");

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !accept)
    else $error("command taken during clearing sweep");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= FULL_CNT)
    else $error("free count above pool size");

  a_no_free_means_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == eidsig_pkg::STAT_NO_FREE)) |-> ($past(q_count) == '0))
    else $error("no-free status with ids in the queue");

endmodule
`default_nettype wire

// ===== rtl/eidsig_free_queue.sv =====
// Free id FIFO: ring memory with head, tail, fill count and an unwritten-slot bypass.
`timescale 1ns / 1ps
`default_nettype none
module eidsig_free_queue #(
  parameter int ENTITIES = eidsig_pkg::ENTITIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire eidsig_pkg::qctl_t                 ctl,
  input  wire logic [$clog2(ENTITIES)-1:0]       push_id,
  output logic [$clog2(ENTITIES)-1:0]            head_id,
  output logic [$clog2(ENTITIES+1)-1:0]          count,
  output eidsig_pkg::qstat_t                     stat
);

  localparam int ID_W  = $clog2(ENTITIES);
  localparam int CNT_W = $clog2(ENTITIES+1);
  localparam logic [ID_W-1:0]  LAST_POS = ID_W'(ENTITIES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTITIES);

  logic [ID_W-1:0] mem [ENTITIES];

  logic [ID_W-1:0]  head_r, head_nxt;
  logic [ID_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             wrapped_r, wrapped_nxt;   // tail has gone round once: every slot written
  logic [ID_W-1:0]  rd_data_r;
  logic [ID_W-1:0]  rd_pos_r;
  logic             rd_hit_r;                 // slot read was written since reset

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    wrapped_nxt = wrapped_r;
    if (ctl.pop) begin
      head_nxt  = (head_r == LAST_POS) ? '0 : head_r + ID_W'(1);
      count_nxt = count_r - CNT_W'(1);
    end
    if (ctl.push) begin
      tail_nxt  = (tail_r == LAST_POS) ? '0 : tail_r + ID_W'(1);
      count_nxt = count_r + CNT_W'(1);
      if (tail_r == LAST_POS) begin
        wrapped_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= FULL_CNT;
      wrapped_r <= 1'b0;
      rd_hit_r  <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      wrapped_r <= wrapped_nxt;
      rd_hit_r  <= wrapped_r || (head_r < tail_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= push_id;
    end
    rd_data_r <= mem[head_r];
    rd_pos_r  <= head_r;
  end

  // A slot never written stands for its reset id, which equals its position, so the position is given.
  assign head_id    = rd_hit_r ? rd_data_r : rd_pos_r;
  assign count      = count_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == FULL_CNT);

endmodule
`default_nettype wire

// ===== rtl/eidsig_entity_store.sv =====
// Per-id alive bit and signature memories with a clearing sweep after reset.
`timescale 1ns / 1ps
`default_nettype none
module eidsig_entity_store #(
  parameter int ENTITIES   = eidsig_pkg::ENTITIES_DEF,
  parameter int COMPONENTS = eidsig_pkg::COMPONENTS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  rd_en,
  input  wire logic [$clog2(ENTITIES)-1:0]           rd_addr,
  input  wire eidsig_pkg::estore_wr_t                wr,
  input  wire logic [$clog2(ENTITIES)-1:0]           alive_addr,
  input  wire logic [$clog2(ENTITIES)-1:0]           sig_addr,
  input  wire logic [((COMPONENTS < eidsig_pkg::SIG_PORT_W) ? COMPONENTS :
                      eidsig_pkg::SIG_PORT_W)-1:0]   sig_data,
  output logic                                       rd_alive,
  output logic [((COMPONENTS < eidsig_pkg::SIG_PORT_W) ? COMPONENTS :
                 eidsig_pkg::SIG_PORT_W)-1:0]        rd_sig,
  output logic                                       clearing
);

  localparam int ID_W  = $clog2(ENTITIES);
  localparam int SIG_W = (COMPONENTS < eidsig_pkg::SIG_PORT_W) ? COMPONENTS :
                         eidsig_pkg::SIG_PORT_W;
  localparam logic [ID_W-1:0] LAST_ID = ID_W'(ENTITIES - 1);

  logic             alive_mem [ENTITIES];
  logic [SIG_W-1:0] sig_mem   [ENTITIES];

  logic            clearing_r;
  logic [ID_W-1:0] clr_addr_r;

  logic             a_we, a_val, s_we;
  logic [ID_W-1:0]  a_addr, s_addr;
  logic [SIG_W-1:0] s_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + ID_W'(1);
      if (clr_addr_r == LAST_ID) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Sweep owns both write ports while it runs
  always_comb begin
    a_we   = clearing_r || wr.alive_we;
    a_val  = clearing_r ? 1'b0 : wr.alive_val;
    a_addr = clearing_r ? clr_addr_r : alive_addr;
    s_we   = clearing_r || wr.sig_we;
    s_data = clearing_r ? '0 : sig_data;
    s_addr = clearing_r ? clr_addr_r : sig_addr;
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      alive_mem[a_addr] <= a_val;
    end
    if (rd_en) begin
      rd_alive <= alive_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      sig_mem[s_addr] <= s_data;
    end
    if (rd_en) begin
      rd_sig <= sig_mem[rd_addr];
    end
  end

  assign clearing = clearing_r;

endmodule
`default_nettype wire
